/* rtl/pitb_pkg.sv */
// Package for the point-in-triangle barycentric core: defaults, sign codes, pipeline control.
`default_nettype none

package pitb_pkg;

  localparam int PITB_COORD_WIDTH = 32;
  localparam int PITB_FRAC_BITS   = 16;

  // Sign of a sub-area after the tie-break
  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sgn_e;

  // Control that travels with each transaction down the pipeline
  typedef struct packed {
    logic valid;
    logic in_tri;
  } pitb_ctl_t;

endpackage

`default_nettype wire

/* rtl/pitb_div_pipe.sv */
// Three-lane pipelined restoring divider: one quotient bit per stage.
`default_nettype none

module pitb_div_pipe
  import pitb_pkg::*;
#(
  parameter int SUM_WIDTH = 2 * PITB_COORD_WIDTH + 3,
  parameter int QUO_WIDTH = PITB_FRAC_BITS + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  pitb_ctl_t                       ctl_i,
  input  logic [2:0][SUM_WIDTH-1:0]       num_i,
  input  logic [SUM_WIDTH-1:0]            den_i,
  output pitb_ctl_t                       ctl_o,
  output logic [2:0][QUO_WIDTH-1:0]       quo_o
);

  logic [SUM_WIDTH-1:0] rem_q [QUO_WIDTH][3];
  logic [QUO_WIDTH-1:0] quo_q [QUO_WIDTH][3];
  logic [SUM_WIDTH-1:0] den_q [QUO_WIDTH];
  pitb_ctl_t            ctl_q [QUO_WIDTH];

  for (genvar s = 0; s < QUO_WIDTH; s++) begin : g_stage
    logic [SUM_WIDTH:0]   rin  [3];
    logic [QUO_WIDTH-1:0] qin  [3];
    logic [SUM_WIDTH:0]   diff [3];
    logic [2:0]           ge;
    logic [SUM_WIDTH-1:0] din;
    pitb_ctl_t            cin;

    if (s == 0) begin : g_first
      // numerator never exceeds the sum, so the top bit resolves num == den
      assign din = den_i;
      assign cin = ctl_i;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rin[l] = {1'b0, num_i[l]};
        assign qin[l] = '0;
      end
    end else begin : g_next
      assign din = den_q[s-1];
      assign cin = ctl_q[s-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rin[l] = {rem_q[s-1][l], 1'b0};
        assign qin[l] = quo_q[s-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        diff[l] = rin[l] - {1'b0, din};
        ge[l]   = (rin[l] >= {1'b0, din});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else if (en_i) begin
        ctl_q[s] <= cin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= din;
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= ge[l] ? diff[l][SUM_WIDTH-1:0] : rin[l][SUM_WIDTH-1:0];
          quo_q[s][l] <= {qin[l][QUO_WIDTH-2:0], ge[l]};
        end
      end
    end
  end

  assign ctl_o = ctl_q[QUO_WIDTH-1];

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = quo_q[QUO_WIDTH-1][l];
  end

endmodule

`default_nettype wire

/* rtl/point_in_triangle_barycentric_core.sv */
// Top level of the point-in-triangle test with barycentric weights.
`default_nettype none

// Point-in-triangle test with barycentric weights, fully pipelined. Each transaction carries a
// query point and three triangle corners (signed, FRAC_BITS fraction bits) and returns one
// result: an inside flag and three weights in unsigned Q1.FRAC_BITS, truncated toward zero,
// all zero when the point is outside. The corners are translated by the query point and the
// three sub-areas are formed exactly at full width (no saturation); a zero area takes its
// sign from an ordered coordinate tie-break. A new transaction is taken every cycle while the
// output is not stalled. Stages: one for the translation, two for the split multiplies, one
// each for area/sign, magnitude and area sum, then one stage per quotient bit in the
// three-lane restoring divider. in_stall_o follows out_stall_i while a result is waiting at
// the output: the whole pipeline holds together, nothing is dropped.
module point_in_triangle_barycentric_core
  import pitb_pkg::*;
#(
  parameter int COORD_WIDTH = PITB_COORD_WIDTH,
  parameter int FRAC_BITS   = PITB_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic [FRAC_BITS:0]            weight_first_o,
  output logic [FRAC_BITS:0]            weight_second_o,
  output logic [FRAC_BITS:0]            weight_third_o
);

  // Widths
  localparam int DW  = COORD_WIDTH + 1;  // translated coordinate
  localparam int LO  = DW / 2;           // low slice of the multiplier operand
  localparam int HI  = DW - LO;          // signed high slice
  localparam int LLO = DW + LO + 1;      // product with the low slice
  localparam int LHI = DW + HI;          // product with the high slice
  localparam int PW  = 2 * DW;           // full product
  localparam int AW  = PW + 1;           // sub-area, also the area sum
  localparam int QW  = FRAC_BITS + 1;    // weight

  localparam logic [QW+1:0] WONE = (QW + 2)'(1) << FRAC_BITS;
  localparam logic [QW-1:0] WMAX = QW'(1) << FRAC_BITS;

  // Whole pipeline advances together unless a result is held at the output
  logic adv;
  pitb_ctl_t ctl_out;
  assign adv        = !(ctl_out.valid && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: translate corners so the query point sits at the origin
  logic signed [DW-1:0] dx1_q [3], dy1_q [3];
  logic                 v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q[0] <= {corner1_x_i[COORD_WIDTH-1], corner1_x_i} - {query_x_i[COORD_WIDTH-1], query_x_i};
      dy1_q[0] <= {corner1_y_i[COORD_WIDTH-1], corner1_y_i} - {query_y_i[COORD_WIDTH-1], query_y_i};
      dx1_q[1] <= {corner2_x_i[COORD_WIDTH-1], corner2_x_i} - {query_x_i[COORD_WIDTH-1], query_x_i};
      dy1_q[1] <= {corner2_y_i[COORD_WIDTH-1], corner2_y_i} - {query_y_i[COORD_WIDTH-1], query_y_i};
      dx1_q[2] <= {corner3_x_i[COORD_WIDTH-1], corner3_x_i} - {query_x_i[COORD_WIDTH-1], query_x_i};
      dy1_q[2] <= {corner3_y_i[COORD_WIDTH-1], corner3_y_i} - {query_y_i[COORD_WIDTH-1], query_y_i};
    end
  end

  // Stage 2: partial products. Products k and k+1, k even, form one area:
  //   A = y2*x3 - x2*y3, B = y3*x1 - x3*y1, C = y1*x2 - x1*y2
  logic signed [DW-1:0]  op_a [6], op_b [6];
  logic signed [LLO-1:0] plo_d [6], plo_q [6];
  logic signed [LHI-1:0] phi_d [6], phi_q [6];
  logic signed [DW-1:0]  dx2_q [3], dy2_q [3];
  logic                  v2_q;

  always_comb begin
    op_a[0] = dy1_q[1]; op_b[0] = dx1_q[2];
    op_a[1] = dx1_q[1]; op_b[1] = dy1_q[2];
    op_a[2] = dy1_q[2]; op_b[2] = dx1_q[0];
    op_a[3] = dx1_q[2]; op_b[3] = dy1_q[0];
    op_a[4] = dy1_q[0]; op_b[4] = dx1_q[1];
    op_a[5] = dx1_q[0]; op_b[5] = dy1_q[1];
    for (int k = 0; k < 6; k++) begin
      plo_d[k] = LLO'(op_a[k]) * LLO'($signed({1'b0, op_b[k][LO-1:0]}));
      phi_d[k] = LHI'(op_a[k]) * LHI'($signed(op_b[k][DW-1:LO]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
    end
  end

  // Stage 3: recombine partial products
  logic signed [PW-1:0] prod_d [6], prod_q [6];
  logic signed [DW-1:0] dx3_q [3], dy3_q [3];
  logic                 v3_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      prod_d[k] = $signed(({{(PW-LHI){phi_q[k][LHI-1]}}, phi_q[k]} << LO)
                        + {{(PW-LLO){plo_q[k][LLO-1]}}, plo_q[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
    end
  end

  // Stage 4: sub-areas and their signs, with the tie-break for zero areas
  function automatic sgn_e tie_sign(input logic signed [AW-1:0] area,
                                    input logic signed [DW-1:0] ux,
                                    input logic signed [DW-1:0] uy,
                                    input logic signed [DW-1:0] vx,
                                    input logic signed [DW-1:0] vy);
    sgn_e s;
    if (area != '0)     s = area[AW-1] ? SGN_NEG : SGN_POS;
    else if (vy > uy)   s = SGN_POS;
    else if (vy < uy)   s = SGN_NEG;
    else if (ux > vx)   s = SGN_POS;
    else if (ux < vx)   s = SGN_NEG;
    else                s = SGN_ZERO;
    return s;
  endfunction

  logic signed [AW-1:0] area_d [3], area_q [3];
  sgn_e                 sgn_a, sgn_b, sgn_c;
  logic                 in4_q, v4_q;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      area_d[m] = {prod_q[2*m][PW-1], prod_q[2*m]} - {prod_q[2*m+1][PW-1], prod_q[2*m+1]};
    end
    sgn_a = tie_sign(area_d[0], dx3_q[1], dy3_q[1], dx3_q[2], dy3_q[2]);
    sgn_b = tie_sign(area_d[1], dx3_q[2], dy3_q[2], dx3_q[0], dy3_q[0]);
    sgn_c = tie_sign(area_d[2], dx3_q[0], dy3_q[0], dx3_q[1], dy3_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      area_q <= area_d;
      in4_q  <= (sgn_a != SGN_ZERO) && (sgn_b == sgn_a) && (sgn_c == sgn_a);
    end
  end

  // Stage 5: magnitudes
  logic [AW-1:0] mag_q [3];
  logic          in5_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int m = 0; m < 3; m++) begin
        mag_q[m] <= area_q[m][AW-1] ? $unsigned(~area_q[m] + AW'(1)) : $unsigned(area_q[m]);
      end
      in5_q <= in4_q;
    end
  end

  // Stage 6: area sum, the common divisor; a zero sum reports outside
  logic [AW-1:0]       sum_d;
  logic [2:0][AW-1:0]  num_q;
  logic [AW-1:0]       den_q;
  pitb_ctl_t           ctl6_q;

  assign sum_d = mag_q[0] + mag_q[1] + mag_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl6_q <= '0;
    end else if (adv) begin
      ctl6_q.valid  <= v5_q;
      ctl6_q.in_tri <= in5_q && (sum_d != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q[0] <= mag_q[0];
      num_q[1] <= mag_q[1];
      num_q[2] <= mag_q[2];
      den_q    <= sum_d;
    end
  end

  // Stages 7 and on: weights, one quotient bit per stage
  logic [2:0][QW-1:0] quo;

  pitb_div_pipe #(
    .SUM_WIDTH (AW),
    .QUO_WIDTH (QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl6_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .ctl_o  (ctl_out),
    .quo_o  (quo)
  );

  assign out_valid_o     = ctl_out.valid;
  assign inside_res_o    = ctl_out.in_tri;
  assign weight_first_o  = ctl_out.in_tri ? quo[0] : '0;
  assign weight_second_o = ctl_out.in_tri ? quo[1] : '0;
  assign weight_third_o  = ctl_out.in_tri ? quo[2] : '0;

  // Assertions
  logic [QW+1:0] wsum;
  assign wsum = {2'b00, weight_first_o} + {2'b00, weight_second_o} + {2'b00, weight_third_o};

  // truncated weights lose less than one unit each
  a_wsum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inside_res_o |-> (wsum <= WONE) && (wsum + (QW + 2)'(2) >= WONE))
    else $error("weight sum out of range");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |->
      (weight_first_o == '0) && (weight_second_o == '0) && (weight_third_o == '0))
    else $error("nonzero weight on outside result");

  a_full_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (weight_first_o == WMAX) |->
      (weight_second_o == '0) && (weight_third_o == '0))
    else $error("full weight with other weights nonzero");

endmodule

`default_nettype wire
